// ===== rtl/core/selection_handle_hit_test_assert.svh =====
// ---------------------------------------------------------------------------
// selection handle hit test assertion macros
// concurrent assertion wrappers, empty when synthesis is defined
// ---------------------------------------------------------------------------
`ifndef SELECTION_HANDLE_HIT_TEST_ASSERT_SVH
`define SELECTION_HANDLE_HIT_TEST_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sht_pkg.sv =====
// ---------------------------------------------------------------------------
// sht_pkg
// shared types and constants of the selection handle hit test
// ---------------------------------------------------------------------------
package sht_pkg;

    // coordinate width default
    localparam int COORD_BITS_DEF = 16;

    // handle size register
    localparam int HS_BITS = 8;
    localparam logic [HS_BITS-1:0] HS_RESET = 8'd8;

    // configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_IDX_HANDLE_SIZE = 1'b0;

    // side length thresholds in handle sizes
    localparam int CORNER_MULT = 3;
    localparam int EDGE_MULT = 5;

    // grab result codes
    typedef enum logic [3:0] {
        GRAB_NONE = 4'd0,
        GRAB_MOVE = 4'd1,
        GRAB_NW   = 4'd2,
        GRAB_NE   = 4'd3,
        GRAB_SW   = 4'd4,
        GRAB_SE   = 4'd5,
        GRAB_N    = 4'd6,
        GRAB_S    = 4'd7,
        GRAB_W    = 4'd8,
        GRAB_E    = 4'd9
    } grab_t;

endpackage

// ===== rtl/core/sht_apb_regs.sv =====
// ---------------------------------------------------------------------------
// sht_apb_regs
// apb-style configuration register file holding the handle size
// ---------------------------------------------------------------------------
module sht_apb_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sht_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [sht_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [sht_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    output logic [sht_pkg::HS_BITS-1:0]        handle_size
);
    import sht_pkg::*;

    logic                 reg_idx;
    logic                 wr_en;
    logic [HS_BITS-1:0]   handle_size_reg;
    logic [HS_BITS-1:0]   handle_size_next;

    // register index from the word address
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // write decode, other indexes are ignored
    always_comb
    begin
        handle_size_next = handle_size_reg;
        if (wr_en && (reg_idx == REG_IDX_HANDLE_SIZE))
        begin
            handle_size_next = pwdata[HS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_size_reg <= HS_RESET;
        end
        else
        begin
            handle_size_reg <= handle_size_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_IDX_HANDLE_SIZE)
        begin
            prdata = PDATA_BITS'(handle_size_reg);
        end
    end

    assign handle_size = handle_size_reg;

endmodule

// ===== rtl/core/sht_hit_eval.sv =====
// ---------------------------------------------------------------------------
// sht_hit_eval
// parallel handle square compares and priority pick of the grab code
// ---------------------------------------------------------------------------
module sht_hit_eval
#(
    parameter int COORD_BITS = sht_pkg::COORD_BITS_DEF
)
(
    input  logic signed [COORD_BITS-1:0]   sel_left,
    input  logic signed [COORD_BITS-1:0]   sel_top,
    input  logic signed [COORD_BITS-1:0]   sel_right,
    input  logic signed [COORD_BITS-1:0]   sel_bottom,
    input  logic signed [COORD_BITS-1:0]   point_x,
    input  logic signed [COORD_BITS-1:0]   point_y,
    input  logic [sht_pkg::HS_BITS-1:0]    handle_size,
    output sht_pkg::grab_t                 grab_code
);
    import sht_pkg::*;

    // room for side lengths, handle bounds and five handle sizes
    localparam int EW = COORD_BITS + HS_BITS + 4;
    localparam int NUM_HANDLES = 8;
    localparam int NUM_CORNERS = 4;

    logic signed [EW-1:0] l;
    logic signed [EW-1:0] t;
    logic signed [EW-1:0] r;
    logic signed [EW-1:0] b;
    logic signed [EW-1:0] px;
    logic signed [EW-1:0] py;
    logic signed [EW-1:0] hs;
    logic signed [EW-1:0] half;
    logic signed [EW-1:0] w;
    logic signed [EW-1:0] h;
    logic signed [EW-1:0] mx;
    logic signed [EW-1:0] my;
    logic signed [EW-1:0] lim_corner;
    logic signed [EW-1:0] lim_edge;
    logic signed [EW-1:0] cx [NUM_HANDLES];
    logic signed [EW-1:0] cy [NUM_HANDLES];
    grab_t                codes [NUM_HANDLES];
    logic [NUM_HANDLES-1:0] hit;
    logic                 corner_en;
    logic                 edge_en;
    logic                 in_rect;

    // widen everything to one exact signed width
    assign l  = EW'(sel_left);
    assign t  = EW'(sel_top);
    assign r  = EW'(sel_right);
    assign b  = EW'(sel_bottom);
    assign px = EW'(point_x);
    assign py = EW'(point_y);
    assign hs = EW'(handle_size);

    // sides, midpoints and thresholds
    assign w          = r - l;
    assign h          = b - t;
    assign half       = hs >>> 1;
    assign mx         = l + (w >>> 1);
    assign my         = t + (h >>> 1);
    assign lim_corner = EW'(hs * CORNER_MULT);
    assign lim_edge   = EW'(hs * EDGE_MULT);

    assign corner_en = (hs != '0) && (w >= lim_corner) && (h >= lim_corner);
    assign edge_en   = corner_en && (w >= lim_edge) && (h >= lim_edge);

    // handle centers in test order
    always_comb
    begin
        cx[0] = l;  cy[0] = t;  codes[0] = GRAB_NW;
        cx[1] = r;  cy[1] = t;  codes[1] = GRAB_NE;
        cx[2] = l;  cy[2] = b;  codes[2] = GRAB_SW;
        cx[3] = r;  cy[3] = b;  codes[3] = GRAB_SE;
        cx[4] = mx; cy[4] = t;  codes[4] = GRAB_N;
        cx[5] = mx; cy[5] = b;  codes[5] = GRAB_S;
        cx[6] = l;  cy[6] = my; codes[6] = GRAB_W;
        cx[7] = r;  cy[7] = my; codes[7] = GRAB_E;
    end

    // half-open square compare per handle
    always_comb
    begin
        for (int i = 0; i < NUM_HANDLES; i++)
        begin
            hit[i] = (px >= cx[i] - half) && (px < cx[i] - half + hs) &&
                     (py >= cy[i] - half) && (py < cy[i] - half + hs);
        end
    end

    assign in_rect = (px >= l) && (px < r) && (py >= t) && (py < b);

    // first hit wins, then move or none
    always_comb
    begin
        logic found;
        found     = 1'b0;
        grab_code = in_rect ? GRAB_MOVE : GRAB_NONE;
        for (int i = 0; i < NUM_HANDLES; i++)
        begin
            if (!found && hit[i] && ((i < NUM_CORNERS) ? corner_en : edge_en))
            begin
                grab_code = codes[i];
                found     = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/selection_handle_hit_test.sv =====
// ---------------------------------------------------------------------------
// selection_handle_hit_test
// reports which grab handle of a selection rectangle a pointer is on
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_stall    | sel_left sel_top sel_right sel_bottom
//          |                        | point_x point_y
//  out     | out_valid / out_stall  | grab_code
//  cfg     | psel penable pwrite    | paddr pwdata prdata (pready tied high)
//
//  one transaction per cycle sustained while out_stall is low; from input to result:
//  an input register, then the compare logic into the result register
//  a result waiting under out_stall leaves the input register free, so one
//  more transaction is taken before in_stall rises
//  reset clears both valid flags and sets the handle size to eight
// ---------------------------------------------------------------------------
`include "selection_handle_hit_test_assert.svh"

module selection_handle_hit_test
#(
    parameter int COORD_BITS = sht_pkg::COORD_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sht_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [sht_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [sht_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_BITS-1:0]       sel_left,
    input  logic signed [COORD_BITS-1:0]       sel_top,
    input  logic signed [COORD_BITS-1:0]       sel_right,
    input  logic signed [COORD_BITS-1:0]       sel_bottom,
    input  logic signed [COORD_BITS-1:0]       point_x,
    input  logic signed [COORD_BITS-1:0]       point_y,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [3:0]                         grab_code
);
    import sht_pkg::*;

    logic [HS_BITS-1:0]              handle_size;
    logic                            in_accept;
    logic                            s2_load;
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic signed [COORD_BITS-1:0]    left_reg;
    logic signed [COORD_BITS-1:0]    top_reg;
    logic signed [COORD_BITS-1:0]    right_reg;
    logic signed [COORD_BITS-1:0]    bottom_reg;
    logic signed [COORD_BITS-1:0]    px_reg;
    logic signed [COORD_BITS-1:0]    py_reg;
    grab_t                           code_next;
    grab_t                           code_reg;

    // configuration registers
    sht_apb_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .handle_size (handle_size)
    );

    // pipeline flow control
    assign s2_load   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s2_load;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
        if (s2_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_reg   <= sel_left;
            top_reg    <= sel_top;
            right_reg  <= sel_right;
            bottom_reg <= sel_bottom;
            px_reg     <= point_x;
            py_reg     <= point_y;
        end
    end

    // handle compares
    sht_hit_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval
    (
        .sel_left    (left_reg),
        .sel_top     (top_reg),
        .sel_right   (right_reg),
        .sel_bottom  (bottom_reg),
        .point_x     (px_reg),
        .point_y     (py_reg),
        .handle_size (handle_size),
        .grab_code   (code_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign grab_code = code_reg;

    // assertions
    `SHT_ASSERT_IMP(a_full_stage_stalls, clk, rst_n, s1_valid_reg && !s2_load, in_stall)
    `SHT_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid_reg && out_stall, !s2_load)
    `SHT_ASSERT_NXT(a_load_gives_result, clk, rst_n, s2_load, out_valid)

endmodule
